// File: rtl/kmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg: shared definitions of the keypad matrix debounce unit
// Matrix size, field widths, debounce phases, register indexes and the
// batch of events that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package kmd_pkg;

   localparam int ROWS = 4;
   localparam int COLS = 4;

   localparam int ROW_IN_W    = 3;
   localparam int LEVEL_W     = 8;
   localparam int TIME_W      = 16;
   localparam int KEY_W       = 6;
   localparam int CSR_INDEX_W = 2;

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

   // Event queue between front and back; depth is a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [TIME_W-1:0] CLOSING_MS_RESET = 16'd20;
   localparam logic [TIME_W-1:0] OPENING_MS_RESET = 16'd20;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSING_MS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPENING_MS = 2'd1;

   typedef enum logic [1:0] {
      PH_OPENED  = 2'd0,
      PH_CLOSING = 2'd1,
      PH_CLOSED  = 2'd2,
      PH_OPENING = 2'd3
   } phase_type;

   // Events of one scanned row: which columns fire and in which direction.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COLS-1:0]  events;
      logic [COLS-1:0]  pressed;
   } kmd_batch_type;

endpackage : kmd_pkg
`default_nettype wire

// File: rtl/kmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_front: row intake and per-key debounce
// Holds the debounce phase and start time of every key and the two timing
// registers. An accepted row in range updates its keys; events form a batch.
// ----------------------------------------------------------------------------
module kmd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [kmd_pkg::ROW_IN_W-1:0]         req_row,
   input  wire logic [kmd_pkg::LEVEL_W-1:0]          req_column_levels,
   input  wire logic [kmd_pkg::TIME_W-1:0]           req_now_ms,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [kmd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [kmd_pkg::TIME_W-1:0]           csr_wdata,
   input  wire logic                                 queue_full,
   output      logic                                 push,
   output      kmd_pkg::kmd_batch_type               push_batch
);
   import kmd_pkg::*;

   phase_type          phase_ff [ROWS][COLS];
   logic [TIME_W-1:0]  start_ff [ROWS][COLS];
   logic [TIME_W-1:0]  closing_ms_ff, closing_ms_in;
   logic [TIME_W-1:0]  opening_ms_ff, opening_ms_in;

   phase_type          lane_phase_in [COLS];
   logic               lane_start_wr [COLS];
   logic [TIME_W-1:0]  lane_elapsed  [COLS];
   logic [COLS-1:0]    lane_event;
   logic [COLS-1:0]    lane_pressed;

   logic               accept;
   logic               row_ok;
   logic [ROW_W-1:0]   row_idx;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign row_ok    = ({1'b0, req_row} < (ROW_IN_W + 1)'(ROWS));
   assign row_idx   = req_row[ROW_W-1:0];

   // Each column is an independent lane of the scanned row.
   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         lane_elapsed[c]  = req_now_ms - start_ff[row_idx][c];
         lane_phase_in[c] = phase_ff[row_idx][c];
         lane_start_wr[c] = 1'b0;
         lane_event[c]    = 1'b0;
         lane_pressed[c]  = 1'b0;
         unique case (phase_ff[row_idx][c])
            PH_OPENED: begin
               if (!req_column_levels[c]) begin
                  lane_phase_in[c] = PH_CLOSING;
                  lane_start_wr[c] = 1'b1;
               end
            end
            PH_CLOSING: begin
               if (req_column_levels[c]) begin
                  lane_phase_in[c] = PH_OPENED;
               end else if (lane_elapsed[c] >= closing_ms_ff) begin
                  lane_phase_in[c] = PH_CLOSED;
                  lane_event[c]    = 1'b1;
                  lane_pressed[c]  = 1'b1;
               end
            end
            PH_CLOSED: begin
               if (req_column_levels[c]) begin
                  lane_phase_in[c] = PH_OPENING;
                  lane_start_wr[c] = 1'b1;
               end
            end
            default: begin
               if (!req_column_levels[c]) begin
                  lane_phase_in[c] = PH_CLOSED;
               end else if (lane_elapsed[c] >= opening_ms_ff) begin
                  lane_phase_in[c] = PH_OPENED;
                  lane_event[c]    = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      closing_ms_in = closing_ms_ff;
      opening_ms_in = opening_ms_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLOSING_MS: closing_ms_in = csr_wdata;
            CSR_OPENING_MS: opening_ms_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closing_ms_ff <= CLOSING_MS_RESET;
         opening_ms_ff <= OPENING_MS_RESET;
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               phase_ff[r][c] <= PH_OPENED;
            end
         end
      end else begin
         closing_ms_ff <= closing_ms_in;
         opening_ms_ff <= opening_ms_in;
         if (accept && row_ok) begin
            for (int c = 0; c < COLS; c++) begin
               phase_ff[row_idx][c] <= lane_phase_in[c];
            end
         end
      end
   end

   // Start times are always written before they are read, so no reset.
   always_ff @(posedge clock) begin
      if (accept && row_ok) begin
         for (int c = 0; c < COLS; c++) begin
            if (lane_start_wr[c]) begin
               start_ff[row_idx][c] <= req_now_ms;
            end
         end
      end
   end

   assign push               = accept && row_ok && (lane_event != '0);
   assign push_batch.row     = row_idx;
   assign push_batch.events  = lane_event;
   assign push_batch.pressed = lane_pressed;

endmodule : kmd_front
`default_nettype wire

// File: rtl/kmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_queue: event batch queue
// A short first-in first-out store of event batches that lets the front
// part and the back part stall independently.
// ----------------------------------------------------------------------------
module kmd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire kmd_pkg::kmd_batch_type  push_batch,
   output      logic                    full,
   input  wire logic                    pop,
   output      logic                    head_valid,
   output      kmd_pkg::kmd_batch_type  head_batch
);
   import kmd_pkg::*;

   kmd_batch_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_batch = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointers wrap on their own because the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_batch;
      end
   end

endmodule : kmd_queue
`default_nettype wire

// File: rtl/kmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_back: event serializer
// Takes event batches from the queue and sends their events, lowest column
// first, one per cycle unless stalled, through a registered result stage.
// ----------------------------------------------------------------------------
module kmd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire kmd_pkg::kmd_batch_type  head_batch,
   output      logic                    pop,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [kmd_pkg::KEY_W-1:0] rsp_key_code,
   output      logic                    rsp_pressed,
   output      logic                    rsp_last
);
   import kmd_pkg::*;

   logic               work_valid_ff, work_valid_in;
   logic [ROW_W-1:0]   work_row_ff, work_row_in;
   logic [COLS-1:0]    work_mask_ff, work_mask_in;
   logic [COLS-1:0]    work_pressed_ff, work_pressed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_code_ff, rsp_key_code_in;
   logic               rsp_pressed_ff, rsp_pressed_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               emit;
   logic [COL_W-1:0]   pick;
   logic [COLS-1:0]    rest;

   always_comb begin
      pick = '0;
      for (int c = COLS - 1; c >= 0; c--) begin
         if (work_mask_ff[c]) begin
            pick = COL_W'(c);
         end
      end
   end

   // Clearing the lowest set bit leaves the events still to be sent.
   assign rest     = work_mask_ff & (work_mask_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = work_valid_ff && out_free;
   assign pop      = head_valid && (!work_valid_ff || (emit && (rest == '0)));

   always_comb begin
      work_valid_in   = work_valid_ff;
      work_row_in     = work_row_ff;
      work_mask_in    = work_mask_ff;
      work_pressed_in = work_pressed_ff;
      if (pop) begin
         work_valid_in   = 1'b1;
         work_row_in     = head_batch.row;
         work_mask_in    = head_batch.events;
         work_pressed_in = head_batch.pressed;
      end else if (emit) begin
         work_valid_in = (rest != '0);
         work_mask_in  = rest;
      end

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_key_code_in = rsp_key_code_ff;
      rsp_pressed_in  = rsp_pressed_ff;
      rsp_last_in     = rsp_last_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_key_code_in = KEY_W'(KEY_W'(work_row_ff) * KEY_W'(COLS)) + KEY_W'(pick);
         rsp_pressed_in  = work_pressed_ff[pick];
         rsp_last_in     = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_row_ff     <= work_row_in;
      work_mask_ff    <= work_mask_in;
      work_pressed_ff <= work_pressed_in;
      rsp_key_code_ff <= rsp_key_code_in;
      rsp_pressed_ff  <= rsp_pressed_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_key_code_ff;
   assign rsp_pressed  = rsp_pressed_ff;
   assign rsp_last     = rsp_last_ff;

endmodule : kmd_back
`default_nettype wire

// File: rtl/keypad_matrix_debounce_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_unit: matrix keypad scanner with per-key debounce
// Debounces every key of the scanned rows and reports key-down and key-up
// events with their key codes.
// ----------------------------------------------------------------------------
//   Channel   Direction   Carries
//   req_      in          row, column levels, time in ms (one scanned row)
//   rsp_      out         key code, pressed flag, last flag (one event)
//   csr_      in          register index and write data
//
// The front part takes a row whenever the event queue has room and updates
// the row's keys at once. The back part sends one event a cycle while the
// result channel is not stalled, so a row with n events yields n items.
// Reset sets all keys open and both timing registers to 20 ms.
// A stalled result channel fills the two-entry queue and then holds off req_.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [kmd_pkg::ROW_IN_W-1:0]      req_row,
   input  wire logic [kmd_pkg::LEVEL_W-1:0]       req_column_levels,
   input  wire logic [kmd_pkg::TIME_W-1:0]        req_now_ms,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [kmd_pkg::KEY_W-1:0]         rsp_key_code,
   output      logic                              rsp_pressed,
   output      logic                              rsp_last,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [kmd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kmd_pkg::TIME_W-1:0]        csr_wdata
);
   import kmd_pkg::*;

   logic           push;
   kmd_batch_type  push_batch;
   logic           queue_full;
   logic           pop;
   logic           head_valid;
   kmd_batch_type  head_batch;

   kmd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_column_levels (req_column_levels),
      .req_now_ms        (req_now_ms),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .queue_full        (queue_full),
      .push              (push),
      .push_batch        (push_batch)
   );

   kmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_batch (push_batch),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_batch (head_batch)
   );

   kmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_batch   (head_batch),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_key_code (rsp_key_code),
      .rsp_pressed  (rsp_pressed),
      .rsp_last     (rsp_last)
   );

endmodule : keypad_matrix_debounce_unit
`default_nettype wire

// File: sim/keypad_matrix_debounce_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_unit_tb: self-checking bench of the keypad debouncer
// Sends scanned rows with a simulated keypad (held keys, contact bounce and
// stray rows), predicts the key-down and key-up items of every accepted row
// and compares them in order with the rsp_ channel under random flow control.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce_unit_tb;
   import kmd_pkg::*;

   localparam int NUM_KEYS     = ROWS * COLS;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // Indexes beyond the two timing registers; writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [ROW_IN_W-1:0] row;
      logic [LEVEL_W-1:0]  levels;
      logic [TIME_W-1:0]   now_ms;
   } scan_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic             pressed;
      logic             last;
   } key_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ROW_IN_W-1:0]    req_row = '0;
   logic [LEVEL_W-1:0]     req_column_levels = '0;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [KEY_W-1:0]       rsp_key_code;
   logic                   rsp_pressed;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]      csr_wdata = '0;

   scan_type       pending_scans[$];
   key_report_type expected_reports[$];
   int             scans_queued = 0;
   int             scans_taken = 0;
   int             csr_writes = 0;
   int             mismatches = 0;
   int             cycles = 0;
   logic           req_taken = 1'b0;

   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   // Debounce state as the block should hold it.
   phase_type         key_mode[NUM_KEYS];
   logic [TIME_W-1:0] key_mark_ms[NUM_KEYS];
   logic [TIME_W-1:0] close_wait_ms = CLOSING_MS_RESET;
   logic [TIME_W-1:0] open_wait_ms = OPENING_MS_RESET;

   // Simulated keypad: 1 = key released (column reads open).
   logic [NUM_KEYS-1:0] key_released = '1;
   logic [TIME_W-1:0]   scan_ms = '0;
   int                  next_row = 0;

   keypad_matrix_debounce_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row           (req_row),
      .req_column_levels (req_column_levels),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_code      (rsp_key_code),
      .rsp_pressed       (rsp_pressed),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // Runs every key of one accepted row through its debounce phases and
   // queues the items the row should produce, in column order.
   task automatic debounce_row(input scan_type scan);
      logic [COLS-1:0]   fired;
      logic [COLS-1:0]   went_down;
      logic [TIME_W-1:0] elapsed;
      key_report_type    report;
      int                key;
      fired = '0;
      went_down = '0;
      if (scan.row >= ROWS) return;
      for (int c = 0; c < COLS; c++) begin
         key = scan.row * COLS + c;
         elapsed = scan.now_ms - key_mark_ms[key];
         case (key_mode[key])
            PH_OPENED: begin
               if (!scan.levels[c]) begin
                  key_mark_ms[key] = scan.now_ms;
                  key_mode[key] = PH_CLOSING;
               end
            end
            PH_CLOSING: begin
               if (scan.levels[c]) begin
                  key_mode[key] = PH_OPENED;
               end else if (elapsed >= close_wait_ms) begin
                  key_mode[key] = PH_CLOSED;
                  fired[c] = 1'b1;
                  went_down[c] = 1'b1;
               end
            end
            PH_CLOSED: begin
               if (scan.levels[c]) begin
                  key_mark_ms[key] = scan.now_ms;
                  key_mode[key] = PH_OPENING;
               end
            end
            default: begin
               if (!scan.levels[c]) begin
                  key_mode[key] = PH_CLOSED;
               end else if (elapsed >= open_wait_ms) begin
                  key_mode[key] = PH_OPENED;
                  fired[c] = 1'b1;
               end
            end
         endcase
      end
      for (int c = 0; c < COLS; c++) begin
         if (fired[c]) begin
            report.key_code = KEY_W'(scan.row * COLS + c);
            report.pressed = went_down[c];
            report.last = ((fired >> (c + 1)) == '0);
            expected_reports.push_back(report);
         end
      end
   endtask

   // Driver of the req_ channel.
   always @(negedge clock) begin : drive_scans
      scan_type next_scan;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_scans.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            next_scan = pending_scans.pop_front();
            req_valid <= 1'b1;
            req_row <= next_scan.row;
            req_column_levels <= next_scan.levels;
            req_now_ms <= next_scan.now_ms;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver flow control, with a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: updates the prediction on every accepted row or register write
   // and checks every accepted result item against the oldest expectation.
   always @(posedge clock) begin : watch_channels
      key_report_type want;
      scan_type       seen;
      if (reset) begin
         req_taken <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_mode[k] = PH_OPENED;
            key_mark_ms[k] = '0;
         end
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOSING_MS: close_wait_ms = csr_wdata;
               CSR_OPENING_MS: open_wait_ms = csr_wdata;
               default: ;
            endcase
            csr_writes <= csr_writes + 1;
         end
         if (req_valid && req_ready) begin
            seen.row = req_row;
            seen.levels = req_column_levels;
            seen.now_ms = req_now_ms;
            debounce_row(seen);
            scans_taken <= scans_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected item: key_code=%0d pressed=%0d last=%0d",
                           rsp_key_code, rsp_pressed, rsp_last);
               end
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (want.key_code !== rsp_key_code || want.pressed !== rsp_pressed ||
                   want.last !== rsp_last) begin
                  if (mismatches < 10) begin
                     $display({"mismatch: expected key_code=%0d pressed=%0d last=%0d,",
                               " got %0d %0d %0d"},
                              want.key_code, want.pressed, want.last,
                              rsp_key_code, rsp_pressed, rsp_last);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_scan(input logic [ROW_IN_W-1:0] row, input logic [LEVEL_W-1:0] levels,
                            input logic [TIME_W-1:0] now_ms);
      scan_type scan;
      scan.row = row;
      scan.levels = levels;
      scan.now_ms = now_ms;
      pending_scans.push_back(scan);
      scans_queued++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [TIME_W-1:0] value);
      int seen;
      @(negedge clock);
      seen = csr_writes;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      while (csr_writes == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued row is taken and every expected item has come,
   // then lets the block settle on rows that produced nothing.
   task automatic wait_drained();
      @(negedge clock);
      while (scans_taken != scans_queued || expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Scans the simulated keypad row by row while keys are pressed and
   // released, with contact bounce and the odd stray row thrown in.
   task automatic scan_keypad(input int count);
      logic [ROW_IN_W-1:0] row;
      logic [LEVEL_W-1:0]  levels;
      int                  taken;
      int                  key;
      taken = 0;
      while (taken < count) begin
         if ($urandom_range(99) < 10) begin
            row = ROW_IN_W'($urandom_range(7));
            push_scan(row, LEVEL_W'($urandom), TIME_W'($urandom));
         end else begin
            row = ROW_IN_W'(next_row);
            next_row = (next_row + 1) % ROWS;
            levels = LEVEL_W'($urandom);
            for (int c = 0; c < COLS; c++) begin
               key = row * COLS + c;
               if ($urandom_range(99) < 8) key_released[key] = ~key_released[key];
               levels[c] = key_released[key] ^ ($urandom_range(99) < 12);
            end
            scan_ms = scan_ms + TIME_W'($urandom_range(3));
            push_scan(row, levels, scan_ms);
         end
         if (row < ROWS) taken++;
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing of 20 ms: settle, bounce back, wrap of the time, all
      // four keys of a row at once, rows past the matrix, unused columns.
      push_scan(0, 8'hFE, 16'd0);
      push_scan(0, 8'hFE, 16'd19);
      push_scan(0, 8'hFE, 16'd20);
      push_scan(0, 8'hFF, 16'd25);
      push_scan(0, 8'hFE, 16'd30);
      push_scan(0, 8'hFF, 16'd40);
      push_scan(0, 8'hFF, 16'd60);
      push_scan(3, 8'h00, 16'd65530);
      push_scan(3, 8'h00, 16'd14);
      push_scan(1, 8'hF5, 16'd100);
      push_scan(1, 8'hFF, 16'd105);
      push_scan(4, 8'h00, 16'd0);
      push_scan(7, 8'h00, 16'd0);
      push_scan(2, 8'h0F, 16'd200);
      push_scan(3, 8'hFF, 16'd300);
      push_scan(3, 8'hFF, 16'd320);
      wait_drained();

      // Zero thresholds still need one more scan before the item.
      write_reg(CSR_CLOSING_MS, 16'd0);
      write_reg(CSR_OPENING_MS, 16'd0);
      push_scan(2, 8'hFE, 16'd500);
      push_scan(2, 8'hFE, 16'd500);
      push_scan(2, 8'hFF, 16'd500);
      push_scan(2, 8'hFF, 16'd500);
      wait_drained();

      // Longest thresholds; writes to spare indexes must leave them alone.
      write_reg(CSR_CLOSING_MS, 16'hFFFF);
      write_reg(CSR_OPENING_MS, 16'hFFFF);
      write_reg(CSR_SPARE_2, 16'h0000);
      write_reg(CSR_SPARE_3, 16'h0001);
      push_scan(2, 8'hFD, 16'd1000);
      push_scan(2, 8'hFD, 16'd1001);
      push_scan(2, 8'hFD, 16'd999);
      push_scan(2, 8'hFF, 16'd7);
      push_scan(2, 8'hFF, 16'd6);
      wait_drained();

      // Back-pressure: the receiver holds off while whole rows go down and
      // up, four items per row, until the block stops taking rows.
      write_reg(CSR_CLOSING_MS, 16'd0);
      write_reg(CSR_OPENING_MS, 16'd0);
      hold_requests = hold_requests + 1;
      for (int rnd = 0; rnd < 6; rnd++) begin
         for (int r = 0; r < ROWS; r++) begin
            scan_ms = scan_ms + 16'd1;
            push_scan(ROW_IN_W'(r), ((rnd % 4) >= 2) ? 8'hFF : 8'h00, scan_ms);
         end
      end
      wait_drained();
      scan_keypad(30);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
            default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
         endcase
         write_reg(CSR_CLOSING_MS, TIME_W'($urandom_range(12)));
         write_reg(CSR_OPENING_MS, TIME_W'($urandom_range(12)));
         scan_keypad(40);
         wait_drained();
         scan_keypad(40);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
